FILE: rtl/mste_pkg.sv
// ----------------------------------------------------------------------------
// mste_pkg
// Shared types and codes for the multi stack transfer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mste_pkg;

  // Stack index field width, fixed by the transaction format
  localparam int unsigned IDX_W = 4;

  // Operation codes
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_MOVE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SRC_EMPTY = 2'd1;
  localparam logic [1:0] ST_DST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] first_stack;
    logic [IDX_W-1:0] second_stack;
    logic [7:0]       count;
    logic [7:0]       crate_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] top_crate;
    logic [7:0] moved;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_H_A,
    S_H_B,
    S_EXEC,
    S_MV_CHK,
    S_MV_WR,
    S_WB_A,
    S_WB_B,
    S_TOP_RD,
    S_TOP_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/mste_ram.sv
// ----------------------------------------------------------------------------
// mste_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mste_height_file.sv
// ----------------------------------------------------------------------------
// mste_height_file
// Per-stack height store: RAM plus valid bits, unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mste_height_file #(
  parameter int unsigned NUM_STACKS = 16,
  parameter int unsigned WIDTH      = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          we,
  input  wire logic [$clog2(NUM_STACKS)-1:0] waddr,
  input  wire logic [WIDTH-1:0]              wdata,
  input  wire logic [$clog2(NUM_STACKS)-1:0] raddr,
  output logic      [WIDTH-1:0]              rdata
);

  logic [NUM_STACKS-1:0] valid;
  logic                  valid_q;
  logic [WIDTH-1:0]      ram_rdata;

  mste_ram #(
    .WIDTH (WIDTH),
    .DEPTH (NUM_STACKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      valid_q <= (raddr < NUM_STACKS) && valid[raddr];
    end
  end

  assign rdata = valid_q ? ram_rdata : '0;

endmodule

`default_nettype wire

FILE: rtl/multi_stack_transfer_engine.sv
// ----------------------------------------------------------------------------
// multi_stack_transfer_engine
// Byte stacks in one shared store: push, move n crates, read top.
// ----------------------------------------------------------------------------
// Sequence: heights read (S_H_A, S_H_B), S_EXEC, heights written back (S_WB_A,
//   S_WB_B), top read (S_TOP_RD), done (S_TOP_OUT); a move loops S_MV_CHK and
//   S_MV_WR, one crate store read and write per crate, plus the final check.
// Throughput: one transaction at a time; busy drops in the result cycle, so
//   the next transaction may be accepted at the edge that takes the result.
// Reset: clears the FSM and the height valid bits (all stacks empty); the
//   crate store is not cleared and needs no sweep. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_stack_transfer_engine
  import mste_pkg::*;
#(
  parameter int unsigned NUM_STACKS  = 16,
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t request,
  output logic      done,
  output rsp_t      result
);

  // Widths derived from the stack geometry
  localparam int unsigned SW = $clog2(NUM_STACKS);               // stack select
  localparam int unsigned HW = $clog2(STACK_DEPTH + 1);          // height
  localparam int unsigned AW = $clog2(NUM_STACKS * STACK_DEPTH); // crate store
  localparam logic [HW-1:0] FULL_H = HW'(STACK_DEPTH);

  state_t state, state_next;

  // Latched transaction and working copies of both stack heights
  req_t          req_q;
  logic          a_ok, b_ok;       // stack index is below NUM_STACKS
  logic [HW-1:0] ha, hb;
  logic [1:0]    status_q;
  logic [7:0]    moved_q;          // doubles as the move loop counter
  logic          rd_top;           // store read data is the reported top

  // Height file port
  logic          h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  logic [HW-1:0] h_wdata, h_rdata;

  // Crate store port
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [7:0]    s_wdata, s_rdata;

  logic          accept;
  logic          a_empty, a_full, b_full, same, is_move, is_push;
  logic [IDX_W-1:0] tgt_idx;
  logic          tgt_ok;
  logic [HW-1:0] tgt_h;

  // Entry s*STACK_DEPTH + p of the crate store holds position p of stack s
  function automatic logic [AW-1:0] store_addr(input logic [IDX_W-1:0] stk,
                                               input logic [HW-1:0]    pos);
    logic [AW-1:0] base;
    base = AW'(stk) * AW'(STACK_DEPTH);
    return base + AW'(pos);
  endfunction

  mste_height_file #(
    .NUM_STACKS (NUM_STACKS),
    .WIDTH      (HW)
  ) u_heights (
    .clk   (clk),
    .rst   (rst),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  mste_ram #(
    .WIDTH (8),
    .DEPTH (NUM_STACKS * STACK_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // --------------------------------------------------------------------------
  // Conditions. An index at or beyond NUM_STACKS acts as always empty and full.
  // --------------------------------------------------------------------------
  assign busy    = !(state == S_IDLE || state == S_TOP_OUT);
  assign accept  = start && !busy;
  assign a_empty = !a_ok || (ha == '0);
  assign a_full  = !a_ok || (ha == FULL_H);
  assign b_full  = !b_ok || (hb == FULL_H);
  assign same    = (req_q.first_stack == req_q.second_stack);
  assign is_move = (req_q.mode == MODE_MOVE);
  assign is_push = (req_q.mode == MODE_PUSH);

  // The reported top comes from the destination of a move, else the first stack
  assign tgt_idx = is_move ? req_q.second_stack : req_q.first_stack;
  assign tgt_ok  = is_move ? b_ok : a_ok;
  assign tgt_h   = is_move ? hb : ha;

  // --------------------------------------------------------------------------
  // State register and next state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_H_A;
      S_H_A:     state_next = S_H_B;
      S_H_B:     state_next = S_EXEC;
      S_EXEC:    state_next = is_move ? S_MV_CHK : S_WB_A;
      S_MV_CHK: begin
        // Loop head: count done, empty source, self move, full destination
        priority if (moved_q == req_q.count) state_next = S_WB_A;
        else if (a_empty)                    state_next = S_WB_A;
        else if (same)                       state_next = S_WB_A;
        else if (b_full)                     state_next = S_WB_A;
        else                                 state_next = S_MV_WR;
      end
      S_MV_WR:   state_next = S_MV_CHK;
      S_WB_A:    state_next = S_WB_B;
      S_WB_B:    state_next = S_TOP_RD;
      S_TOP_RD:  state_next = S_TOP_OUT;
      S_TOP_OUT: state_next = start ? S_H_A : S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    h_we    = 1'b0;
    h_waddr = SW'(req_q.first_stack);
    h_wdata = ha;
    h_raddr = SW'(request.first_stack);
    s_we    = 1'b0;
    s_waddr = store_addr(req_q.second_stack, hb);
    s_wdata = s_rdata;
    s_raddr = store_addr(req_q.first_stack, ha - 1'b1);
    unique case (state)
      S_IDLE, S_TOP_OUT: h_raddr = SW'(request.first_stack);
      S_H_A:             h_raddr = SW'(req_q.second_stack);
      S_EXEC: begin
        if (is_push && !a_full) begin
          s_we    = 1'b1;
          s_waddr = store_addr(req_q.first_stack, ha);
          s_wdata = req_q.crate_value;
        end
      end
      S_MV_WR:  s_we = 1'b1;  // popped crate lands on the destination
      S_WB_A:   h_we = a_ok;
      S_WB_B: begin
        // Only a move touches the second stack's height
        h_we    = b_ok && is_move;
        h_waddr = SW'(req_q.second_stack);
        h_wdata = hb;
      end
      S_TOP_RD: s_raddr = store_addr(tgt_idx, tgt_h - 1'b1);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q    <= request;
      a_ok     <= (request.first_stack < NUM_STACKS);
      b_ok     <= (request.second_stack < NUM_STACKS);
      status_q <= ST_OK;
      moved_q  <= '0;
    end
    unique case (state)
      S_H_A: ha <= h_rdata;
      S_H_B: hb <= h_rdata;
      S_EXEC: begin
        if (is_push) begin
          if (a_full) begin
            status_q <= ST_DST_FULL;
          end else begin
            ha      <= ha + 1'b1;
            moved_q <= 8'd1;
          end
        end
      end
      S_MV_CHK: begin
        if (moved_q != req_q.count) begin
          priority if (a_empty) status_q <= ST_SRC_EMPTY;
          else if (same)        moved_q  <= req_q.count; // pops and pushes back
          else if (b_full)      status_q <= ST_DST_FULL;
        end
      end
      S_MV_WR: begin
        ha      <= ha - 1'b1;
        hb      <= hb + 1'b1;
        moved_q <= moved_q + 1'b1;
      end
      S_TOP_RD: rd_top <= tgt_ok && (tgt_h != '0) && (req_q.mode != MODE_NOP);
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result: one strobe cycle, top crate straight from the store read register
  // --------------------------------------------------------------------------
  assign done             = (state == S_TOP_OUT);
  assign result.status    = status_q;
  assign result.top_crate = rd_top ? s_rdata : 8'd0;
  assign result.moved     = moved_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_move_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MV_WR) |-> (ha != '0 && hb != FULL_H && !same))
    else $error("crate transfer from an empty or into a full stack");

  a_moved_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.moved <= req_q.count || is_push))
    else $error("more crates reported than requested");

endmodule

`default_nettype wire
